/* hw/rtl/nsp_pkg.sv */
// Package for the note string parser: word types, command codes and defaults.
// Depends on nothing; every other file of the block imports it.
package nsp_pkg;

  // Input word: one character of the note string.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  // Result word: one note event or one error report.
  typedef struct packed {
    logic [3:0]  command_code;
    logic [5:0]  shift_biased;
    logic [2:0]  octave;
    logic [6:0]  velocity;
    logic [10:0] length;
    logic        bad_char;
    logic        end_of_string;
  } out_word_t;

  // Register file contents.
  typedef struct packed {
    logic signed [5:0] start_shift;
    logic [2:0]        start_octave;
    logic [6:0]        default_velocity;
    logic [10:0]       default_length;
  } cfg_t;

  // Up to two results made by one character, queued together.
  typedef struct packed {
    out_word_t first;
    out_word_t second;
    logic      has_second;
  } out_pair_t;

  // Register indexes (byte address is 4 times the index).
  localparam int unsigned CfgAddrWidth = 4;
  typedef enum logic [1:0] {
    REG_START_SHIFT      = 2'd0,
    REG_START_OCTAVE     = 2'd1,
    REG_DEFAULT_VELOCITY = 2'd2,
    REG_DEFAULT_LENGTH   = 2'd3
  } reg_idx_t;

  localparam logic signed [5:0] START_SHIFT_RST      = 6'sd1;
  localparam logic [2:0]        START_OCTAVE_RST     = 3'd4;
  localparam logic [6:0]        DEFAULT_VELOCITY_RST = 7'd100;
  localparam logic [10:0]       DEFAULT_LENGTH_RST   = 11'd120;

  // Command codes; notes A..G are 0..6.
  localparam logic [3:0] CMD_NOTE_LAST = 4'd6;
  localparam logic [3:0] CMD_REST      = 4'd7;
  localparam logic [3:0] CMD_PLUS      = 4'd8;
  localparam logic [3:0] CMD_MINUS     = 4'd9;
  localparam logic [3:0] CMD_SHARP     = 4'd10;
  localparam logic [3:0] CMD_FLAT      = 4'd11;
  localparam logic [3:0] CMD_OCT_UP    = 4'd12;
  localparam logic [3:0] CMD_OCT_DOWN  = 4'd13;
  localparam logic [3:0] CMD_VEL       = 4'd14;
  localparam logic [3:0] CMD_MOD       = 4'd15;

  localparam int unsigned NSP_QUEUE_DEPTH = 2;

endpackage

/* hw/rtl/nsp_cfg_regs.sv */
// APB-style register file of the note string parser.
// Depends on nsp_pkg for cfg_t, register indexes and reset values.
module nsp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsp_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output nsp_pkg::cfg_t                     cfg
);
  import nsp_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_shift      <= START_SHIFT_RST;
      cfg_r.start_octave     <= START_OCTAVE_RST;
      cfg_r.default_velocity <= DEFAULT_VELOCITY_RST;
      cfg_r.default_length   <= DEFAULT_LENGTH_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_SHIFT:      cfg_r.start_shift      <= pwdata[5:0];
        REG_START_OCTAVE:     cfg_r.start_octave     <= pwdata[2:0];
        REG_DEFAULT_VELOCITY: cfg_r.default_velocity <= pwdata[6:0];
        REG_DEFAULT_LENGTH:   cfg_r.default_length   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_SHIFT:      prdata = {26'd0, cfg_r.start_shift};
      REG_START_OCTAVE:     prdata = {29'd0, cfg_r.start_octave};
      REG_DEFAULT_VELOCITY: prdata = {25'd0, cfg_r.default_velocity};
      REG_DEFAULT_LENGTH:   prdata = {21'd0, cfg_r.default_length};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/nsp_parse.sv */
// Input register and single-pass parse step of the note string parser.
// Depends on nsp_pkg for word types and command codes.
module nsp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nsp_pkg::in_word_t    in_word,
  input  nsp_pkg::cfg_t        cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output nsp_pkg::out_pair_t   q_pair
);
  import nsp_pkg::*;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_NOTE  = 4'b0010,
    PH_NUM   = 4'b0100,
    PH_IDLE  = 4'b1000
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [10:0] NUM_MAX = 11'd2047;
  localparam logic [5:0]  SHIFT_ZERO = 6'd32;
  localparam logic [5:0]  SHIFT_TOP  = 6'd63;
  localparam logic [2:0]  OCT_TOP    = 3'd7;

  in_word_t   in_r;
  logic       in_full_r;
  phase_t     phase_r, phase_nxt;
  logic [3:0] pend_r, pend_nxt;
  logic [1:0] acc_cnt_r, acc_cnt_nxt;
  logic [10:0] num_r, num_nxt;
  logic       has_dig_r, has_dig_nxt;
  logic [5:0] shift_r, shift_nxt;
  logic [2:0] oct_r, oct_nxt;

  logic       fire;
  logic       is_digit, is_acc, pending, new_cmd, bad;
  logic [3:0] code;
  logic [14:0] num_wide;
  logic [1:0] n_res;
  out_word_t  res0, res1, bad_word;

  function automatic out_word_t emit_word(input logic [3:0] pcode, input logic [10:0] num,
                                          input logic has_dig, input logic [5:0] sh,
                                          input logic [2:0] oc, input cfg_t c);
    out_word_t  w;
    logic [6:0] num7;
    num7 = (num > 11'd127) ? 7'd127 : num[6:0];
    w.command_code  = pcode;
    w.shift_biased  = sh;
    w.octave        = oc;
    w.velocity      = c.default_velocity;
    w.length        = has_dig ? num : c.default_length;
    w.bad_char      = 1'b0;
    w.end_of_string = 1'b0;
    if (pcode == CMD_VEL) begin
      w.velocity = has_dig ? num7 : c.default_velocity;
      w.length   = c.default_length;
    end else if (pcode == CMD_MOD) begin
      w.velocity = has_dig ? num7 : 7'd0;
      w.length   = c.default_length;
    end
    return w;
  endfunction

  assign fire     = in_full_r && !q_full;
  assign in_stall = in_full_r && !fire;

  always_comb begin
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    acc_cnt_nxt = acc_cnt_r;
    num_nxt     = num_r;
    has_dig_nxt = has_dig_r;
    shift_nxt   = shift_r;
    oct_nxt     = oct_r;
    n_res       = 2'd0;
    res0        = '0;
    res1        = '0;
    new_cmd     = 1'b0;
    bad         = 1'b0;
    code        = '0;
    num_wide    = '0;
    bad_word    = '0;

    is_digit = (in_r.char_code >= CH_ZERO) && (in_r.char_code <= CH_NINE);
    is_acc   = (in_r.char_code == CH_HASH) || (in_r.char_code == CH_EQ);

    // Reload shift and octave on the first character of a string.
    if (phase_r == PH_START) begin
      shift_nxt = {~cfg.start_shift[5], cfg.start_shift[4:0]};
      oct_nxt   = cfg.start_octave;
      phase_nxt = PH_IDLE;
    end
    pending = (phase_nxt == PH_NOTE) || (phase_nxt == PH_NUM);

    if (phase_nxt == PH_NOTE && is_acc && acc_cnt_r != 2'd3) begin
      if (in_r.char_code == CH_HASH) begin
        if (shift_nxt != SHIFT_TOP) shift_nxt = shift_nxt + 6'd1;
      end else begin
        if (shift_nxt != 6'd0) shift_nxt = shift_nxt - 6'd1;
      end
      acc_cnt_nxt = acc_cnt_r + 2'd1;
    end else if (pending && is_digit) begin
      num_wide = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0}
               + {11'd0, in_r.char_code[3:0]};
      num_nxt     = (num_wide > {4'd0, NUM_MAX}) ? NUM_MAX : num_wide[10:0];
      has_dig_nxt = 1'b1;
      phase_nxt   = PH_NUM;
    end else begin
      if (pending) begin
        res0      = emit_word(pend_r, num_r, has_dig_r, shift_nxt, oct_nxt, cfg);
        n_res     = 2'd1;
        phase_nxt = PH_IDLE;
      end
      new_cmd = 1'b1;
      if (in_r.char_code >= CH_A && in_r.char_code <= CH_G) begin
        code      = in_r.char_code[3:0] - CH_A[3:0];
        shift_nxt = SHIFT_ZERO;
      end else begin
        case (in_r.char_code)
          CH_SPACE: new_cmd = 1'b0;
          CH_R:     code = CMD_REST;
          CH_PLUS: begin
            code = CMD_PLUS;
            if (shift_nxt != SHIFT_TOP) shift_nxt = shift_nxt + 6'd1;
          end
          CH_MINUS: begin
            code = CMD_MINUS;
            if (shift_nxt != 6'd0) shift_nxt = shift_nxt - 6'd1;
          end
          CH_HASH: begin
            code = CMD_SHARP;
            if (shift_nxt != SHIFT_TOP) shift_nxt = shift_nxt + 6'd1;
          end
          CH_EQ: begin
            code = CMD_FLAT;
            if (shift_nxt != 6'd0) shift_nxt = shift_nxt - 6'd1;
          end
          CH_LBR, CH_LT: begin
            code = CMD_OCT_UP;
            if (oct_nxt != OCT_TOP) oct_nxt = oct_nxt + 3'd1;
          end
          CH_RBR, CH_GT: begin
            code = CMD_OCT_DOWN;
            if (oct_nxt != 3'd0) oct_nxt = oct_nxt - 3'd1;
          end
          CH_V:     code = CMD_VEL;
          CH_M:     code = CMD_MOD;
          default: begin
            new_cmd = 1'b0;
            bad     = 1'b1;
          end
        endcase
      end
      if (new_cmd) begin
        pend_nxt    = code;
        acc_cnt_nxt = 2'd0;
        num_nxt     = 11'd0;
        has_dig_nxt = 1'b0;
        phase_nxt   = (code <= CMD_NOTE_LAST) ? PH_NOTE : PH_NUM;
      end else if (bad) begin
        bad_word.shift_biased = shift_nxt;
        bad_word.octave       = oct_nxt;
        bad_word.bad_char     = 1'b1;
        if (n_res == 2'd0) res0 = bad_word;
        else res1 = bad_word;
        n_res = n_res + 2'd1;
      end
    end

    // End of string: flush the held command, mark the last result.
    if (in_r.last_char) begin
      if (phase_nxt == PH_NOTE || phase_nxt == PH_NUM) begin
        if (n_res == 2'd0) begin
          res0 = emit_word(pend_nxt, num_nxt, has_dig_nxt, shift_nxt, oct_nxt, cfg);
        end else begin
          res1 = emit_word(pend_nxt, num_nxt, has_dig_nxt, shift_nxt, oct_nxt, cfg);
        end
        n_res = n_res + 2'd1;
      end
      if (n_res == 2'd1) res0.end_of_string = 1'b1;
      if (n_res == 2'd2) res1.end_of_string = 1'b1;
      phase_nxt = PH_START;
    end
  end

  assign q_push            = fire && (n_res != 2'd0);
  assign q_pair.first      = res0;
  assign q_pair.second     = res1;
  assign q_pair.has_second = n_res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      phase_r   <= PH_START;
      pend_r    <= '0;
      acc_cnt_r <= '0;
      num_r     <= '0;
      has_dig_r <= 1'b0;
      shift_r   <= {~START_SHIFT_RST[5], START_SHIFT_RST[4:0]};
      oct_r     <= START_OCTAVE_RST;
    end else begin
      if (in_valid && !in_stall) begin
        in_full_r <= 1'b1;
      end else if (fire) begin
        in_full_r <= 1'b0;
      end
      if (fire) begin
        phase_r   <= phase_nxt;
        pend_r    <= pend_nxt;
        acc_cnt_r <= acc_cnt_nxt;
        num_r     <= num_nxt;
        has_dig_r <= has_dig_nxt;
        shift_r   <= shift_nxt;
        oct_r     <= oct_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_word;
  end

endmodule

/* hw/rtl/nsp_pair_queue.sv */
// Parser result queue: holds result pairs, sends one word a cycle unless stalled.
// Depends on nsp_pkg for out_pair_t and out_word_t.
module nsp_pair_queue #(
  parameter int unsigned DEPTH = nsp_pkg::NSP_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsp_pkg::out_pair_t  push_pair,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output nsp_pkg::out_word_t  out_word
);
  import nsp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  out_pair_t         mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   cnt_r;
  logic              sel_r;
  out_pair_t         head;
  logic              take, pop;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (cnt_r != '0);
  assign full      = (cnt_r == CntW'(DEPTH));
  assign out_word  = sel_r ? head.second : head.first;
  assign take      = out_valid && !out_stall;
  assign pop       = take && (sel_r || !head.has_second);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sel_r    <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
      if (take) sel_r <= !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_pair;
  end

endmodule

/* hw/rtl/note_string_parser.sv */
// Top level of the note string parser: register file, parse stage, result queue.
// Depends on nsp_pkg, nsp_cfg_regs, nsp_parse and nsp_pair_queue.
//
//   channel | direction | handshake                  | word
//   in_     | input     | in_valid / in_stall        | in_word_t  (char_code, last_char)
//   out_    | output    | out_valid / out_stall      | out_word_t (command .. end_of_string)
//   cfg     | input     | psel penable pwrite pready | 32-bit registers at 4*index
//
// A character is accepted into the input register and parsed there in one
// pass once the queue has room, which writes zero, one or two results as
// one queue entry. The queue sends one word a cycle while out_stall is low,
// so the single output port sets the sustained rate: a character making two
// results sends two words.
// Reset is synchronous and active low; it clears the queue and restarts the
// string state. A stall on the output holds the word and fills the queue;
// the input stalls only when the queue is full and the input register is busy.
module note_string_parser #(
  parameter int unsigned QUEUE_DEPTH = nsp_pkg::NSP_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nsp_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nsp_pkg::out_word_t                out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsp_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import nsp_pkg::*;

  cfg_t      cfg;
  logic      q_full;
  logic      q_push;
  out_pair_t q_pair;

  // Configuration registers; the user must write them only while the parser is idle; the block does not enforce it.
  nsp_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold one character, advance the string state and build its results.
  nsp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_pair   (q_pair)
  );

  // Queue result pairs and drain them one word at a time.
  nsp_pair_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_pair (q_pair),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* hw/rtl/nsp_checker.sv */
// Port-level checks for the note string parser, bound to its top level.
// Depends on nsp_pkg for the word types.
module nsp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input nsp_pkg::in_word_t                 in_word,
  input logic                              out_valid,
  input logic                              out_stall,
  input nsp_pkg::out_word_t                out_word,
  input logic                              psel,
  input logic                              pready
);
  import nsp_pkg::*;

  // Stalled character stays put.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("character changed while stalled");

  // Stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // Nothing left over after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Error reports carry no command, velocity or length.
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_char |->
      out_word.command_code == '0 && out_word.velocity == '0 && out_word.length == '0)
    else $error("error report with payload");

  // Register port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel |-> pready)
    else $error("pready low");

endmodule

bind note_string_parser nsp_checker u_nsp_checker (.*);
